FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the box transform RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, quiet while reset is held
`define AAT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
// clocked check that also holds through reset
`define AAT_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define AAT_ASSERT(label, prop)
`define AAT_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: design/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared constants and register codes for the box transform block.
// ----------------------------------------------------------------------------
package aat_pkg;

	// default field widths
	localparam int COORD_WIDTH_DEF = 32;
	localparam int COEFF_WIDTH_DEF = 16;

	// one row of coefficients per output axis, one column per input axis
	localparam int NUM_AXES = 3;

	// configuration port geometry: registers at 8-byte strides
	localparam int PDATA_WIDTH = 64;
	localparam int PADDR_WIDTH = 6;
	localparam int REG_IDX_LSB = 3;
	localparam int REG_IDX_W   = PADDR_WIDTH - REG_IDX_LSB;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROW_X   = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ROW_Y   = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_ROW_Z   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z = REG_IDX_W'(5);

endpackage

FILE: design/aat_cfg_regs.sv
// ----------------------------------------------------------------------------
// aat_cfg_regs
// APB-style register file holding the coefficient rows and translations.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aat_cfg_regs import aat_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_WIDTH-1:0]        paddr,
	input  logic [PDATA_WIDTH-1:0]        pwdata,
	output logic [PDATA_WIDTH-1:0]        prdata,
	output logic                          pready,
	output logic [3*COEFF_WIDTH-1:0]      row_q   [NUM_AXES],
	output logic signed [COORD_WIDTH-1:0] shift_q [NUM_AXES]
);

	localparam int ROW_W = 3 * COEFF_WIDTH;
	localparam int FRAC  = COEFF_WIDTH - 2;

	logic                          wr_en;
	logic [REG_IDX_W-1:0]          idx;
	logic [ROW_W+PDATA_WIDTH-1:0]  row_wide;
	logic [COORD_WIDTH+PDATA_WIDTH-1:0] shift_wide;
	logic [ROW_W-1:0]              wr_row;
	logic [COORD_WIDTH-1:0]        wr_shift;

	// write decode, bits above a register's width dropped
	assign pready     = 1'b1;
	assign wr_en      = psel & penable & pwrite;
	assign idx        = paddr[PADDR_WIDTH-1:REG_IDX_LSB];
	assign row_wide   = {{ROW_W{1'b0}}, pwdata};
	assign shift_wide = {{COORD_WIDTH{1'b0}}, pwdata};
	assign wr_row     = row_wide[ROW_W-1:0];
	assign wr_shift   = shift_wide[COORD_WIDTH-1:0];

	// register storage, reset to a diagonal scale of 1, 1/4 and 1/16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= ROW_W'(1) << FRAC;
			row_q[1]   <= (ROW_W'(1) << (FRAC - 2)) << COEFF_WIDTH;
			row_q[2]   <= (ROW_W'(1) << (FRAC - 4)) << (2 * COEFF_WIDTH);
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_ROW_X:   row_q[0]   <= wr_row;
				REG_ROW_Y:   row_q[1]   <= wr_row;
				REG_ROW_Z:   row_q[2]   <= wr_row;
				REG_SHIFT_X: shift_q[0] <= $signed(wr_shift);
				REG_SHIFT_Y: shift_q[1] <= $signed(wr_shift);
				REG_SHIFT_Z: shift_q[2] <= $signed(wr_shift);
				default: ;
			endcase
		end
	end

	// read back, zero extended to the bus
	always_comb begin
		logic [ROW_W+PDATA_WIDTH-1:0]       rw;
		logic [COORD_WIDTH+PDATA_WIDTH-1:0] sw;
		rw = '0;
		sw = '0;
		unique case (idx)
			REG_ROW_X:   rw = {{PDATA_WIDTH{1'b0}}, row_q[0]};
			REG_ROW_Y:   rw = {{PDATA_WIDTH{1'b0}}, row_q[1]};
			REG_ROW_Z:   rw = {{PDATA_WIDTH{1'b0}}, row_q[2]};
			REG_SHIFT_X: sw = {{PDATA_WIDTH{1'b0}}, shift_q[0]};
			REG_SHIFT_Y: sw = {{PDATA_WIDTH{1'b0}}, shift_q[1]};
			REG_SHIFT_Z: sw = {{PDATA_WIDTH{1'b0}}, shift_q[2]};
			default: ;
		endcase
		prdata = rw[PDATA_WIDTH-1:0] | sw[PDATA_WIDTH-1:0];
	end

	`AAT_ASSERT(a_shift_x_write, (wr_en && idx == REG_SHIFT_X) |=> (shift_q[0] == $signed($past(wr_shift))))
	`AAT_ASSERT(a_row_x_write, (wr_en && idx == REG_ROW_X) |=> (row_q[0] == $past(wr_row)))

endmodule

FILE: design/aat_mul_stage.sv
// ----------------------------------------------------------------------------
// aat_mul_stage
// First pipeline stage: every coefficient times both box extents.
// ----------------------------------------------------------------------------
module aat_mul_stage import aat_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      valid,
	input  logic signed [COORD_WIDTH-1:0]             lo    [NUM_AXES],
	input  logic signed [COORD_WIDTH-1:0]             hi    [NUM_AXES],
	input  logic signed [COEFF_WIDTH-1:0]             coeff [NUM_AXES][NUM_AXES],
	output logic                                      valid_s1,
	output logic signed [COORD_WIDTH+COEFF_WIDTH-1:0] prod_lo_s1 [NUM_AXES][NUM_AXES],
	output logic signed [COORD_WIDTH+COEFF_WIDTH-1:0] prod_hi_s1 [NUM_AXES][NUM_AXES]
);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	// full-width signed products, one per row, column and extent
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_AXES; r++) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				prod_lo_s1[r][c] <= lo[c] * coeff[r][c];
				prod_hi_s1[r][c] <= hi[c] * coeff[r][c];
			end
		end
	end

endmodule

FILE: design/aat_bound_stage.sv
// ----------------------------------------------------------------------------
// aat_bound_stage
// Second pipeline stage: floors each product and keeps the smaller and the
// larger of the two extents per row and column.
// ----------------------------------------------------------------------------
module aat_bound_stage import aat_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      valid_s1,
	input  logic signed [COORD_WIDTH+COEFF_WIDTH-1:0] prod_lo_s1 [NUM_AXES][NUM_AXES],
	input  logic signed [COORD_WIDTH+COEFF_WIDTH-1:0] prod_hi_s1 [NUM_AXES][NUM_AXES],
	output logic                                      valid_s2,
	output logic signed [COORD_WIDTH+1:0]             min_s2 [NUM_AXES][NUM_AXES],
	output logic signed [COORD_WIDTH+1:0]             max_s2 [NUM_AXES][NUM_AXES]
);

	localparam int PW   = COORD_WIDTH + COEFF_WIDTH;
	localparam int FRAC = COEFF_WIDTH - 2;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// dropping the fraction bits of a two's complement value floors it
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_AXES; r++) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				if ($signed(prod_lo_s1[r][c][PW-1:FRAC]) < $signed(prod_hi_s1[r][c][PW-1:FRAC])) begin
					min_s2[r][c] <= $signed(prod_lo_s1[r][c][PW-1:FRAC]);
					max_s2[r][c] <= $signed(prod_hi_s1[r][c][PW-1:FRAC]);
				end else begin
					min_s2[r][c] <= $signed(prod_hi_s1[r][c][PW-1:FRAC]);
					max_s2[r][c] <= $signed(prod_lo_s1[r][c][PW-1:FRAC]);
				end
			end
		end
	end

endmodule

FILE: design/aat_sum_stage.sv
// ----------------------------------------------------------------------------
// aat_sum_stage
// Third and fourth pipeline stages: sums the per-column bounds with the
// translation, then saturates into the output register.
// ----------------------------------------------------------------------------
module aat_sum_stage import aat_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	input  logic signed [COORD_WIDTH-1:0] shift  [NUM_AXES],
	input  logic signed [COORD_WIDTH+1:0] min_s2 [NUM_AXES][NUM_AXES],
	input  logic signed [COORD_WIDTH+1:0] max_s2 [NUM_AXES][NUM_AXES],
	output logic                          valid_s4,
	output logic signed [COORD_WIDTH-1:0] lo_s4  [NUM_AXES],
	output logic signed [COORD_WIDTH-1:0] hi_s4  [NUM_AXES]
);

	localparam int SW = COORD_WIDTH + 4;

	logic                 valid_s3;
	logic signed [SW-1:0] lo_sum_s3 [NUM_AXES];
	logic signed [SW-1:0] hi_sum_s3 [NUM_AXES];

	// saturate a sum to the coordinate range
	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
		logic [SW-COORD_WIDTH:0] top;
		top = v[SW-1:COORD_WIDTH-1];
		if ((&top) || !(|top)) begin
			sat = $signed(v[COORD_WIDTH-1:0]);
		end else if (v[SW-1]) begin
			sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
	endfunction

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// exact sums of translation and column bounds
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_AXES; r++) begin
			lo_sum_s3[r] <= SW'(shift[r]) + SW'(min_s2[r][0]) + SW'(min_s2[r][1])
				+ SW'(min_s2[r][2]);
			hi_sum_s3[r] <= SW'(shift[r]) + SW'(max_s2[r][0]) + SW'(max_s2[r][1])
				+ SW'(max_s2[r][2]);
		end
	end

	// saturation into the output register
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_AXES; r++) begin
			lo_s4[r] <= sat(lo_sum_s3[r]);
			hi_s4[r] <= sat(hi_sum_s3[r]);
		end
	end

endmodule

FILE: design/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Bounding box of an axis-aligned box after a configurable affine map.
// ----------------------------------------------------------------------------
// One box is taken on every clock cycle (busy stays low) and its bounds pass
// through multiply, floor and per-column min/max, sum with translation and
// saturate, marked at the end by a one-cycle done strobe. The result is shown
// only in that cycle, as the receiver cannot stall; throughput is one box per
// cycle, fixed by the fully pipelined bank of eighteen coefficient
// multipliers. Since each floored product depends on one input axis only, the
// bounds are the sums of per-column extremes, which equals bounding all eight
// corners. The user must write registers through the APB port only while no
// box is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_affine_transform import aat_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] lo_x,
	input  logic signed [COORD_WIDTH-1:0] lo_y,
	input  logic signed [COORD_WIDTH-1:0] lo_z,
	input  logic signed [COORD_WIDTH-1:0] hi_x,
	input  logic signed [COORD_WIDTH-1:0] hi_y,
	input  logic signed [COORD_WIDTH-1:0] hi_z,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] out_lo_x,
	output logic signed [COORD_WIDTH-1:0] out_lo_y,
	output logic signed [COORD_WIDTH-1:0] out_lo_z,
	output logic signed [COORD_WIDTH-1:0] out_hi_x,
	output logic signed [COORD_WIDTH-1:0] out_hi_y,
	output logic signed [COORD_WIDTH-1:0] out_hi_z,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_WIDTH-1:0]        paddr,
	input  logic [PDATA_WIDTH-1:0]        pwdata,
	output logic [PDATA_WIDTH-1:0]        prdata,
	output logic                          pready
);

	localparam int PW = COORD_WIDTH + COEFF_WIDTH;

	logic [3*COEFF_WIDTH-1:0]      row_q   [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] shift_q [NUM_AXES];
	logic signed [COEFF_WIDTH-1:0] coeff   [NUM_AXES][NUM_AXES];
	logic signed [COORD_WIDTH-1:0] lo      [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi      [NUM_AXES];
	logic                          accept;
	logic                          valid_s1;
	logic                          valid_s2;
	logic signed [PW-1:0]          prod_lo_s1 [NUM_AXES][NUM_AXES];
	logic signed [PW-1:0]          prod_hi_s1 [NUM_AXES][NUM_AXES];
	logic signed [COORD_WIDTH+1:0] min_s2 [NUM_AXES][NUM_AXES];
	logic signed [COORD_WIDTH+1:0] max_s2 [NUM_AXES][NUM_AXES];
	logic signed [COORD_WIDTH-1:0] lo_s4  [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi_s4  [NUM_AXES];

	// the pipeline never stalls, so every start is a transfer
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// box extents gathered per axis
	assign lo[0] = lo_x;
	assign lo[1] = lo_y;
	assign lo[2] = lo_z;
	assign hi[0] = hi_x;
	assign hi[1] = hi_y;
	assign hi[2] = hi_z;

	// coefficient fields unpacked from the rows
	always_comb begin
		for (int r = 0; r < NUM_AXES; r++) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				coeff[r][c] = $signed(row_q[r][c*COEFF_WIDTH +: COEFF_WIDTH]);
			end
		end
	end

	aat_cfg_regs #(
		.COORD_WIDTH (COORD_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.row_q   (row_q),
		.shift_q (shift_q)
	);

	aat_mul_stage #(
		.COORD_WIDTH (COORD_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (accept),
		.lo         (lo),
		.hi         (hi),
		.coeff      (coeff),
		.valid_s1   (valid_s1),
		.prod_lo_s1 (prod_lo_s1),
		.prod_hi_s1 (prod_hi_s1)
	);

	aat_bound_stage #(
		.COORD_WIDTH (COORD_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_bound (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.prod_lo_s1 (prod_lo_s1),
		.prod_hi_s1 (prod_hi_s1),
		.valid_s2   (valid_s2),
		.min_s2     (min_s2),
		.max_s2     (max_s2)
	);

	aat_sum_stage #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.shift    (shift_q),
		.min_s2   (min_s2),
		.max_s2   (max_s2),
		.valid_s4 (done),
		.lo_s4    (lo_s4),
		.hi_s4    (hi_s4)
	);

	// result ports
	assign out_lo_x = lo_s4[0];
	assign out_lo_y = lo_s4[1];
	assign out_lo_z = lo_s4[2];
	assign out_hi_x = hi_s4[0];
	assign out_hi_y = hi_s4[1];
	assign out_hi_z = hi_s4[2];

	`AAT_ASSERT(a_start_gives_done, accept |-> ##4 done)
	`AAT_ASSERT(a_done_from_start, done |-> $past(accept, 4))
	`AAT_ASSERT(a_bounds_ordered, done |-> (out_lo_x <= out_hi_x && out_lo_y <= out_hi_y && out_lo_z <= out_hi_z))
	`AAT_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |=> !done)

endmodule

FILE: verif/aabb_affine_transform_tb.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_tb
// Self-checking bench for the box transform block. A short table of boxes
// runs under the reset matrix, some rows with hand-worked bounds. Then several
// register settings follow, among them the full positive and full negative
// coefficient extremes. Each setting gets a burst of random boxes, checked
// against a bench-side model of the eight-corner bounding.
// ----------------------------------------------------------------------------
module aabb_affine_transform_tb;
	import aat_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [COORD_WIDTH_DEF-1:0] word_t;

	typedef struct packed {
		word_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	} box_t;

	typedef struct packed {
		box_t stim;
		bit   typed;
		box_t want;
	} box_vector_t;

	// spare decodes beyond the last register, writes there must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = REG_IDX_W'(7);

	localparam int     FRAC_BITS    = COEFF_WIDTH_DEF - 2;
	localparam longint SAT_MAX      = 64'sh7fff_ffff;
	localparam longint SAT_MIN      = -64'sh8000_0000;
	localparam int     IDLE_PCT     = 29;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     NUM_PHASES   = 8;
	localparam int     PHASE_BOXES  = 200;
	localparam int     QUIET_PHASE  = 4;

	logic clk;
	logic arst_n = 1'b0;

	logic  start = 1'b0;
	logic  busy;
	word_t lo_x = '0, lo_y = '0, lo_z = '0, hi_x = '0, hi_y = '0, hi_z = '0;
	logic  done;
	word_t out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z;

	logic                   psel    = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite  = 1'b0;
	logic [PADDR_WIDTH-1:0] paddr   = '0;
	logic [PDATA_WIDTH-1:0] pwdata  = '0;
	logic [PDATA_WIDTH-1:0] prdata;
	logic                   pready;

	// bench copy of the transform registers
	logic        [47:0] row_coef  [3] = '{48'd16384, 48'd268435456, 48'd4398046511104};
	logic signed [31:0] shift_val [3] = '{32'sd0, 32'sd0, 32'sd0};

	box_t pending_bounds [$];
	int   fault_count = 0;

	string field_name [6] = '{"out_hi_z", "out_hi_y", "out_hi_x",
	                          "out_lo_z", "out_lo_y", "out_lo_x"};

	// reset matrix: x' = x, y' = floor(y / 4), z' = floor(z / 16)
	box_vector_t box_vectors [16] = '{
		'{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
		'{'{-1, -1, -1, -1, -1, -1}, 1'b1, '{-1, -1, -1, -1, -1, -1}},
		'{'{-100, -400, -1600, 100, 400, 1600}, 1'b1,
			'{-100, -100, -100, 100, 100, 100}},
		// inverted box, lo above hi
		'{'{100, 400, 1600, -100, -400, -1600}, 1'b1,
			'{-100, -100, -100, 100, 100, 100}},
		'{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b1,
			'{32'h8000_0000, 32'he000_0000, 32'hf800_0000,
			32'h7fff_ffff, 32'h1fff_ffff, 32'h07ff_ffff}},
		'{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1,
			'{32'h8000_0000, 32'he000_0000, 32'hf800_0000,
			32'h7fff_ffff, 32'h1fff_ffff, 32'h07ff_ffff}},
		'{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1,
			'{32'h8000_0000, 32'he000_0000, 32'hf800_0000,
			32'h8000_0000, 32'he000_0000, 32'hf800_0000}},
		'{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b1,
			'{32'h7fff_ffff, 32'h1fff_ffff, 32'h07ff_ffff,
			32'h7fff_ffff, 32'h1fff_ffff, 32'h07ff_ffff}},
		// flooring toward minus infinity on both signs
		'{'{3, 3, 15, 3, 3, 15}, 1'b1, '{3, 0, 0, 3, 0, 0}},
		'{'{-3, -3, -15, -3, -3, -15}, 1'b1, '{-3, -1, -1, -3, -1, -1}},
		'{'{32'h0001_8000, 32'hfffe_0000, 32'h1234_5678,
			32'h0003_0000, 32'h0002_0001, 32'h1234_5679}, 1'b0, '0},
		'{'{32'hffff_0001, 32'h0000_0003, 32'h8000_0001,
			32'h0000_ffff, 32'hffff_fffd, 32'h7fff_fffe}, 1'b0, '0},
		'{'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0, '0},
		'{'{32'h0000_0007, 32'h0000_0005, 32'hffff_fff1,
			32'h0000_0008, 32'h0000_0006, 32'hffff_fff0}, 1'b0, '0},
		'{'{32'h4000_0000, 32'hc000_0000, 32'h0000_0010,
			32'hc000_0000, 32'h4000_0000, 32'hffff_fff0}, 1'b0, '0},
		'{'{32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h00ff_00ff,
			32'hff00_ff00, 32'h0f0f_0f0f, 32'hf0f0_f0f0}, 1'b0, '0}
	};

	aabb_affine_transform i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bounds of the eight mapped corners, each coordinate saturated first
	function automatic box_t transformed_bounds(box_t b);
		int      lo [3];
		int      hi [3];
		int      pt [3];
		longint  acc;
		longint  bmin [3];
		longint  bmax [3];
		shortint coef;
		box_t    r;
		lo = '{b.lo_x, b.lo_y, b.lo_z};
		hi = '{b.hi_x, b.hi_y, b.hi_z};
		for (int i = 0; i < 8; i++) begin
			for (int a = 0; a < 3; a++)
				pt[a] = i[a] ? hi[a] : lo[a];
			for (int o = 0; o < 3; o++) begin
				acc = longint'(shift_val[o]);
				for (int c = 0; c < 3; c++) begin
					coef = row_coef[o][16*c +: 16];
					acc += (longint'(pt[c]) * longint'(coef)) >>> FRAC_BITS;
				end
				if (acc > SAT_MAX)
					acc = SAT_MAX;
				else if (acc < SAT_MIN)
					acc = SAT_MIN;
				if (i == 0 || acc < bmin[o])
					bmin[o] = acc;
				if (i == 0 || acc > bmax[o])
					bmax[o] = acc;
			end
		end
		r.lo_x = word_t'(bmin[0]);
		r.lo_y = word_t'(bmin[1]);
		r.lo_z = word_t'(bmin[2]);
		r.hi_x = word_t'(bmax[0]);
		r.hi_y = word_t'(bmax[1]);
		r.hi_z = word_t'(bmax[2]);
		return r;
	endfunction

	// mostly full-range values, with the extremes and small values weighted in
	function automatic word_t pick_coord();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return word_t'(int'($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	// one apb write: setup cycle, then access until pready, then back to idle
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_WIDTH-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_WIDTH'(idx) << REG_IDX_LSB;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ROW_X:   row_coef[0]  = data[47:0];
			REG_ROW_Y:   row_coef[1]  = data[47:0];
			REG_ROW_Z:   row_coef[2]  = data[47:0];
			REG_SHIFT_X: shift_val[0] = data[31:0];
			REG_SHIFT_Y: shift_val[1] = data[31:0];
			REG_SHIFT_Z: shift_val[2] = data[31:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offer one box, optionally after random idle cycles, until it is taken
	task automatic send_box(box_t b, bit typed, box_t want, bit may_idle);
		while (may_idle && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		lo_x  <= b.lo_x;
		lo_y  <= b.lo_y;
		lo_z  <= b.lo_z;
		hi_x  <= b.hi_x;
		hi_y  <= b.hi_y;
		hi_z  <= b.hi_z;
		do
			@(posedge clk);
		while (busy);
		pending_bounds.push_back(typed ? want : transformed_bounds(b));
	endtask

	// hold off until every outstanding box has come back, then let the pipe settle
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_bounds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register setting for one phase: extremes first, then zero coefficients with random shifts, then random words
	task automatic load_phase(int phase);
		logic [PDATA_WIDTH-1:0] row_wr [3];
		logic [PDATA_WIDTH-1:0] shift_wr [3];
		for (int k = 0; k < 3; k++) begin
			case (phase)
				0: begin
					row_wr[k]   = {16'hffff, {3{16'h7fff}}};
					shift_wr[k] = {32'hffff_ffff, 32'h7fff_ffff};
				end
				1: begin
					row_wr[k]   = {16'h0000, {3{16'h8000}}};
					shift_wr[k] = {32'h0000_0000, 32'h8000_0000};
				end
				2: begin
					row_wr[k]   = {$urandom, 32'h0} & 64'hffff_0000_0000_0000;
					shift_wr[k] = {$urandom, $urandom};
				end
				default: begin
					row_wr[k]   = {$urandom, $urandom};
					shift_wr[k] = {$urandom, $urandom};
				end
			endcase
		end
		write_reg(REG_ROW_X, row_wr[0]);
		write_reg(REG_ROW_Y, row_wr[1]);
		write_reg(REG_ROW_Z, row_wr[2]);
		write_reg(REG_SHIFT_X, shift_wr[0]);
		write_reg(REG_SHIFT_Y, shift_wr[1]);
		write_reg(REG_SHIFT_Z, shift_wr[2]);
		write_reg(phase[0] ? REG_SPARE_B : REG_SPARE_A, {$urandom, $urandom});
	endtask

	// stimulus
	initial begin
		box_t b;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (box_vectors[n])
			send_box(box_vectors[n].stim, box_vectors[n].typed, box_vectors[n].want, 1'b1);
		wait_idle();
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			load_phase(phase);
			for (int n = 0; n < PHASE_BOXES; n++) begin
				b = '{pick_coord(), pick_coord(), pick_coord(),
				      pick_coord(), pick_coord(), pick_coord()};
				send_box(b, 1'b0, '0, phase != QUIET_PHASE);
			end
			wait_idle();
		end
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// result check, one transfer per done strobe
	always @(posedge clk) begin : check_results
		box_t                         got;
		box_t                         want;
		logic [5:0][COORD_WIDTH_DEF-1:0] got_w;
		logic [5:0][COORD_WIDTH_DEF-1:0] want_w;
		if (arst_n && done) begin
			got = '{out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z};
			if (pending_bounds.size() == 0) begin
				$error("result transfer with no box outstanding");
				fault_count++;
			end else begin
				want   = pending_bounds.pop_front();
				got_w  = got;
				want_w = want;
				for (int k = 0; k < 6; k++) begin
					if (got_w[k] !== want_w[k]) begin
						$error("%s: expected %0d, actual %0d", field_name[k],
							$signed(want_w[k]), $signed(got_w[k]));
						fault_count++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
